[rtl/sida_pkg.sv]
// ----------------------------------------------------------------------------
// sida_pkg: shared types and constants
// Character codes, BCD digit constants and the state type of the conversion back end.
// ----------------------------------------------------------------------------
package sida_pkg;

  // ASCII codes that the block emits.
  localparam logic [7:0] CharZero  = 8'd48;
  localparam logic [7:0] CharMinus = 8'd45;

  // BCD digit limits and the shift-add-3 correction.
  localparam logic [3:0] DigitMax    = 4'd9;
  localparam logic [3:0] DigitAdjMin = 4'd5;
  localparam logic [3:0] DigitAdj    = 4'd3;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    BkIdle,
    BkConv,
    BkScan,
    BkSign,
    BkDigit
  } back_state_e;

endpackage

[rtl/sida_front.sv]
// ----------------------------------------------------------------------------
// sida_front: input side
// Accepts one signed integer per transfer, splits it into a sign flag and an
// unsigned magnitude, and pushes both into the work queue.
// ----------------------------------------------------------------------------
module sida_front #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  input  logic                          full_i,
  output logic                          push_o,
  output logic [VALUE_WIDTH:0]          item_o
);

  logic [VALUE_WIDTH-1:0] raw;
  logic                   negative;
  logic [VALUE_WIDTH-1:0] magnitude;

  // The magnitude fits in VALUE_WIDTH unsigned bits, the most negative value
  // included: negating it gives back the same pattern, read as unsigned.
  assign raw       = value_i;
  assign negative  = raw[VALUE_WIDTH-1];
  assign magnitude = negative ? (VALUE_WIDTH'(~raw) + VALUE_WIDTH'(1)) : raw;

  // A transfer is taken whenever the queue has room.
  assign in_stall_o = full_i;
  assign push_o     = in_valid_i & ~full_i;
  assign item_o     = {negative, magnitude};

endmodule

[rtl/sida_fifo.sv]
// ----------------------------------------------------------------------------
// sida_fifo: two-entry work queue
// Decouples the input side from the conversion back end.
// ----------------------------------------------------------------------------
module sida_fifo #(
  parameter int Width = 33
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] data_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_q, wr_d;
  logic             rd_q, rd_d;
  logic [1:0]       count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign data_o  = mem_q[rd_q];

  // Pointer and fill count update.
  always_comb begin
    wr_d    = push_i ? ~wr_q : wr_q;
    rd_d    = pop_i ? ~rd_q : rd_q;
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // The front end never pushes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("sida_fifo: push while full");

  // The back end never pops an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("sida_fifo: pop while empty");

endmodule

[rtl/sida_back.sv]
// ----------------------------------------------------------------------------
// sida_back: conversion back end
// Turns one queued magnitude into BCD by shift-add-3, one bit per cycle,
// finds the leading digit, then emits a minus sign for a negative number and
// the digits as ASCII through a registered output.
// ----------------------------------------------------------------------------
module sida_back #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  logic [VALUE_WIDTH:0] item_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           char_code_o,
  output logic                 last_char_o
);

  import sida_pkg::*;

  // Enough BCD digits for 2^(VALUE_WIDTH-1).
  localparam int NumDigits = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int BcdBits   = NumDigits * 4;
  localparam int CntWidth  = $clog2(VALUE_WIDTH);
  localparam int IdxWidth  = $clog2(NumDigits);

  back_state_e            state_q, state_d;
  logic [VALUE_WIDTH-1:0] bin_q, bin_d;
  logic [BcdBits-1:0]     bcd_q, bcd_d;
  logic [BcdBits-1:0]     bcd_adj;
  logic                   neg_q, neg_d;
  logic [CntWidth-1:0]    cnt_q, cnt_d;
  logic [IdxWidth-1:0]    idx_q, idx_d;
  logic [IdxWidth-1:0]    top_idx;
  logic [3:0]             cur_digit;
  logic                   out_valid_q, out_valid_d;
  logic [7:0]             char_q, char_d;
  logic                   last_q, last_d;
  logic                   out_free;
  logic                   out_load;
  logic                   conv_done;

  assign out_free  = ~out_valid_q | ~out_stall_i;
  assign conv_done = (cnt_q == CntWidth'(VALUE_WIDTH - 1));
  assign cur_digit = bcd_q[idx_q * 4 +: 4];

  // Shift-add-3 correction, each digit on its own.
  always_comb begin
    bcd_adj = bcd_q;
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[i*4 +: 4] >= DigitAdjMin) begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + DigitAdj;
      end
    end
  end

  // Position of the most significant nonzero digit, zero if none.
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[i*4 +: 4] != 4'd0) begin
        top_idx = IdxWidth'(i);
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BkIdle:  if (!empty_i) state_d = BkConv;
      BkConv:  if (conv_done) state_d = BkScan;
      BkScan:  state_d = neg_q ? BkSign : BkDigit;
      BkSign:  if (out_free) state_d = BkDigit;
      BkDigit: if (out_free && idx_q == '0) state_d = BkIdle;
      default: state_d = BkIdle;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    pop_o    = 1'b0;
    out_load = 1'b0;
    bin_d    = bin_q;
    bcd_d    = bcd_q;
    neg_d    = neg_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    char_d   = char_q;
    last_d   = last_q;
    unique case (state_q)
      BkIdle: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          neg_d = item_i[VALUE_WIDTH];
          bin_d = item_i[VALUE_WIDTH-1:0];
          bcd_d = '0;
          cnt_d = '0;
        end
      end
      BkConv: begin
        bcd_d = {bcd_adj[BcdBits-2:0], bin_q[VALUE_WIDTH-1]};
        bin_d = {bin_q[VALUE_WIDTH-2:0], 1'b0};
        cnt_d = cnt_q + CntWidth'(1);
      end
      BkScan: begin
        idx_d = top_idx;
      end
      BkSign: begin
        if (out_free) begin
          out_load = 1'b1;
          char_d   = CharMinus;
          last_d   = 1'b0;
        end
      end
      BkDigit: begin
        if (out_free) begin
          out_load = 1'b1;
          char_d   = CharZero + {4'd0, cur_digit};
          last_d   = (idx_q == '0);
          if (idx_q != '0) begin
            idx_d = idx_q - IdxWidth'(1);
          end
        end
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  // Output register: filled when empty or when its transfer completes.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    neg_q  <= neg_d;
    cnt_q  <= cnt_d;
    idx_q  <= idx_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_char_o = last_q;

  // The sign is only emitted for negative numbers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BkSign) |-> neg_q)
    else $error("sida_back: sign state for a non-negative number");

  // Emitting the lowest digit closes the number and marks it last.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BkDigit && out_free && idx_q == '0) |=>
      (state_q == BkIdle && out_valid_o && last_char_o))
    else $error("sida_back: final digit not marked or sequencer not idle");

  // Every emitted code is a minus sign or a decimal digit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (char_code_o == CharMinus ||
                     (char_code_o >= CharZero &&
                      char_code_o <= CharZero + {4'd0, DigitMax})))
    else $error("sida_back: emitted code is not a sign or a digit");

endmodule

[rtl/signed_int_to_decimal_ascii.sv]
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed integer to decimal ASCII text
// Emits the decimal text of each signed input, most significant character
// first, with a leading minus sign for negative values.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake               | Payload
//   --------+-----------+-------------------------+---------------------------
//   in      | input     | in_valid_i, in_stall_o  | value_i
//   out     | output    | out_valid_o, out_stall_i| char_code_o, last_char_o
//
// An input transfer lands in a two-entry queue; the back end takes one entry
// at a time, loads it, runs bit-serial BCD conversion, finds the leading
// digit, then emits the characters (up to 11 at 32 bits) and only then takes
// the next entry.
// Reset (rst_ni low, asynchronous) empties the queue and the output register.
// An output stall holds the character register; input is stalled only while
// the queue holds two numbers.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    char_code_o,
  output logic                          last_char_o
);

  logic                 push;
  logic                 pop;
  logic                 full;
  logic                 empty;
  logic [VALUE_WIDTH:0] push_item;
  logic [VALUE_WIDTH:0] pop_item;

  sida_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .value_i    (value_i),
    .full_i     (full),
    .push_o     (push),
    .item_o     (push_item)
  );

  sida_fifo #(
    .Width (VALUE_WIDTH + 1)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (pop_item)
  );

  sida_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .item_i      (pop_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .char_code_o (char_code_o),
    .last_char_o (last_char_o)
  );

endmodule

[sim/signed_int_to_decimal_ascii_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_tb: testbench for the signed decimal formatter
// Sends directed edge values and then random signed integers. A scoreboard
// renders each accepted value as decimal text and checks every output
// character and end mark in order. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_tb;
  import sida_pkg::*;

  localparam int ValueWidth  = 32;
  localparam int DigitBase   = 10;
  localparam int RandomCount = 350;
  localparam int CalmCount   = 60;
  localparam int DrainCycles = 80;
  localparam int CycleLimit  = 600000;

  typedef logic signed [ValueWidth-1:0] value_t;

  // One character of decimal text and its end-of-number mark.
  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } text_char_t;

  // Scoreboard: renders accepted values and matches the emitted characters.
  class text_board;
    text_char_t pending_chars[$];
    int         mismatches;

    function new();
      mismatches = 0;
    endfunction

    task report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    // Queue the decimal text of one accepted value.
    function void note_value(input value_t v);
      logic signed [63:0] wide;
      logic [63:0]        mag;
      logic [7:0]         digits[$];
      text_char_t         c;
      bit                 neg;
      neg  = v[ValueWidth-1];
      wide = v;
      mag  = neg ? -wide : wide;
      do begin
        digits.push_front(CharZero + 8'(mag % DigitBase));
        mag = mag / DigitBase;
      end while (mag != 0);
      if (neg) begin
        c.char_code = CharMinus;
        c.last_char = 1'b0;
        pending_chars.push_back(c);
      end
      foreach (digits[k]) begin
        c.char_code = digits[k];
        c.last_char = (k == digits.size() - 1);
        pending_chars.push_back(c);
      end
    endfunction

    // Compare one output transfer with the oldest expected character.
    task check_char(input logic [7:0] code, input logic last);
      text_char_t want;
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character %0d last %0b", code, last));
      end else begin
        want = pending_chars.pop_front();
        if (code !== want.char_code)
          report_mismatch($sformatf("char_code %0d, expected %0d", code, want.char_code));
        if (last !== want.last_char)
          report_mismatch($sformatf("last_char %0b, expected %0b", last, want.last_char));
      end
    endtask
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  value_t     value_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] char_code_o;
  logic       last_char_o;

  text_board board = new();
  bit        idling_on = 1'b1;
  int        cycles_run = 0;

  signed_int_to_decimal_ascii #(
    .VALUE_WIDTH(ValueWidth)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .char_code_o(char_code_o),
    .last_char_o(last_char_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit: a hung block ends the run as a failure.
  initial begin
    while (cycles_run < CycleLimit) begin
      @(posedge clk_i);
      cycles_run++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Send one value, possibly after an idle burst, and wait for its transfer.
  task automatic send_value(input value_t v);
    int gap;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (in_stall_o);
    board.note_value(v);
  endtask

  // Random value with a spread of magnitudes and signs.
  function automatic value_t pick_value();
    value_t v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = $urandom_range(0, 999);
      2: v = $urandom >> $urandom_range(0, 31);
      default: v = ValueWidth'(64'd10 ** $urandom_range(0, 9)) - 1 + $urandom_range(0, 2);
    endcase
    if ($urandom_range(0, 1) != 0) v = -v;
    return v;
  endfunction

  // Output side: check each transfer and stall in random bursts.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i)
        board.check_char(char_code_o, last_char_o);
      if (stall_left == 0 && idling_on && $urandom_range(0, 9) == 0)
        stall_left = $urandom_range(1, 18);
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Reset, directed values, random values, then drain.
  initial begin
    value_t directed[$];
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    value_i     = '0;
    out_stall_i = 1'b0;
    directed = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99,
                 32'sd100, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000001,
                 32'sd1000000000, -32'sd1000000000, 32'sd999999999,
                 32'sh55555555, 32'shAAAAAAAA, 32'sd123456789, -32'sd123456789,
                 32'sd7, -32'sd9, 32'sh0000FFFF, 32'shFFFF0000};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_value(directed[i]);
    for (int n = 0; n < RandomCount; n++) begin
      if (n == RandomCount - CalmCount) idling_on = 1'b0;
      send_value(pick_value());
    end
    in_valid_i <= 1'b0;

    while (board.pending_chars.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (board.mismatches == 0 && board.pending_chars.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
